[rtl/core/ssr_pkg.sv]
`timescale 1ns / 1ps

package ssr_pkg;

  typedef logic signed [31:0] comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  typedef struct packed {
    logic cur_zero;
    logic ref_zero;
  } flags_t;

  typedef enum logic [1:0] {
    MODE_RGB = 2'd0,
    MODE_S   = 2'd1,
    MODE_T   = 2'd2,
    MODE_AVG = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    REG_OUTPUT_MODE = 4'd0,
    REG_USE_WARNING = 4'd1,
    REG_WARN_RED    = 4'd2,
    REG_WARN_GREEN  = 4'd3,
    REG_WARN_BLUE   = 4'd4,
    REG_FATAL_RED   = 4'd5,
    REG_FATAL_GREEN = 4'd6,
    REG_FATAL_BLUE  = 4'd7
  } reg_idx_t;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_CUR = 2'd1;
  localparam logic [1:0] STATUS_REF = 2'd2;

endpackage

[rtl/core/ssr_front.sv]
`timescale 1ns / 1ps

module ssr_front import ssr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         in_valid,
  input  vec_t         ds [2],
  input  vec_t         dt [2],
  output logic         out_valid,
  output logic [127:0] lc_rad [2],
  output logic [63:0]  ld_rad [2],
  output flags_t       flags
);

  logic v1, v2, v3, v4;

  logic signed [63:0] prod [2][6];
  logic signed [63:0] dsq  [2][3];
  logic signed [64:0] dif  [2][3];
  logic [63:0]        cmag [2][3];
  logic [63:0]        cr   [2][3];
  logic [63:0]        dsn2 [2];
  logic [63:0]        dsn3 [2];
  logic [63:0]        dsn4 [2];
  logic               z2   [2];
  logic               z3   [2];
  logic               z4   [2];
  logic               z5   [2];
  logic [63:0]        hh   [2][3];
  logic [63:0]        hl   [2][3];
  logic [63:0]        ll   [2][3];
  logic [127:0]       sq   [2][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_comb begin
    for (int f = 0; f < 2; f++) begin
      dif[f][0] = 65'(prod[f][0]) - 65'(prod[f][1]);
      dif[f][1] = 65'(prod[f][2]) - 65'(prod[f][3]);
      dif[f][2] = 65'(prod[f][4]) - 65'(prod[f][5]);
      for (int k = 0; k < 3; k++) begin
        cmag[f][k] = dif[f][k][64] ? 64'(-dif[f][k]) : dif[f][k][63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int f = 0; f < 2; f++) begin
        // cross terms
        prod[f][0] <= ds[f].y * dt[f].z;
        prod[f][1] <= ds[f].z * dt[f].y;
        prod[f][2] <= ds[f].z * dt[f].x;
        prod[f][3] <= ds[f].x * dt[f].z;
        prod[f][4] <= ds[f].x * dt[f].y;
        prod[f][5] <= ds[f].y * dt[f].x;
        dsq[f][0]  <= ds[f].x * ds[f].x;
        dsq[f][1]  <= ds[f].y * ds[f].y;
        dsq[f][2]  <= ds[f].z * ds[f].z;

        for (int k = 0; k < 3; k++) cr[f][k] <= cmag[f][k];
        dsn2[f] <= unsigned'(dsq[f][0]) + unsigned'(dsq[f][1]) + unsigned'(dsq[f][2]);
        z2[f]   <= (cmag[f][0] == '0) && (cmag[f][1] == '0) && (cmag[f][2] == '0);

        // 64-bit squares as 32x32 partials
        for (int k = 0; k < 3; k++) begin
          hh[f][k] <= cr[f][k][63:32] * cr[f][k][63:32];
          hl[f][k] <= cr[f][k][63:32] * cr[f][k][31:0];
          ll[f][k] <= cr[f][k][31:0] * cr[f][k][31:0];
        end
        dsn3[f] <= dsn2[f];
        z3[f]   <= z2[f];

        for (int k = 0; k < 3; k++) begin
          sq[f][k] <= {hh[f][k], 64'd0} + (128'(hl[f][k]) << 33) + 128'(ll[f][k]);
        end
        dsn4[f] <= dsn3[f];
        z4[f]   <= z3[f];

        lc_rad[f] <= sq[f][0] + sq[f][1] + sq[f][2];
        ld_rad[f] <= dsn4[f];
        z5[f]     <= z4[f];
      end
    end
  end

  assign flags.cur_zero = z5[0];
  assign flags.ref_zero = z5[1];

endmodule

[rtl/core/ssr_sqrt.sv]
`timescale 1ns / 1ps

module ssr_sqrt import ssr_pkg::*; #(
  parameter int RW = 64,
  parameter int SW = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  logic            vld [RW+1];
  logic [RW:0]     rem [RW+1];
  logic [RW-1:0]   rt  [RW+1];
  logic [2*RW-1:0] rd  [RW+1];
  logic [SW-1:0]   sd  [RW+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rd[0]  = rad;
  assign sd[0]  = side_in;

  // one root bit per stage, restoring
  for (genvar i = 0; i < RW; i++) begin : g_step
    logic [RW+2:0] t;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      t     = {rem[i], rd[i][2*RW-1 -: 2]};
      trial = {rt[i], 2'b01};
      ge    = t >= {1'b0, trial};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= ge ? (RW+1)'(t - {1'b0, trial}) : t[RW:0];
        rt[i+1]  <= {rt[i][RW-2:0], ge};
        rd[i+1]  <= {rd[i][2*RW-3:0], 2'b00};
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign side_out  = sd[RW];

endmodule

[rtl/core/ssr_div.sv]
`timescale 1ns / 1ps

module ssr_div import ssr_pkg::*; #(
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [DW-1:0] hi,
  input  logic [QW-1:0] lo,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);

  logic          vld [QW+1];
  logic          ovf [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [SW-1:0] sd  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  // quotient would not fit: saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      ovf[0] <= hi >= den;
      rem[0] <= hi;
      q[0]   <= lo;
      dv[0]  <= den;
      sd[0]  <= side_in;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] t;
    logic        ge;

    always_comb begin
      t  = {rem[i], q[i][QW-1]};
      ge = t >= {1'b0, dv[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= ge ? DW'(t - {1'b0, dv[i]}) : t[DW-1:0];
        q[i+1]   <= {q[i][QW-2:0], ge};
        dv[i+1]  <= dv[i];
        ovf[i+1] <= ovf[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot      = ovf[QW] ? '1 : q[QW];
  assign side_out  = sd[QW];

endmodule

[rtl/core/ssr_delay.sv]
`timescale 1ns / 1ps

module ssr_delay import ssr_pkg::*; #(
  parameter int W = 32,
  parameter int N = 32
) (
  input  logic         clk,
  input  logic         adv,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    if (adv) begin
      line[0] <= din;
      for (int i = 1; i < N; i++) line[i] <= line[i-1];
    end
  end

  assign dout = line[N-1];

endmodule

[rtl/core/surface_stretch_ratio_top.sv]
`timescale 1ns / 1ps

// Surface stretch ratio. Takes one request per cycle unless a result is held on
// result_stall, and returns one result per request, in order, by way of: products
// and squares, bit-serial square root on the 128-bit cross-product norm,
// pipelined division for the perpendicular dP/dt lengths, the three ratio
// divisions and one output register. The whole pipeline holds while a result
// waits on result_stall, so item_stall follows it. Configuration writes are
// always ready and should only be made while the
// pipeline is empty.
module surface_stretch_ratio_top import ssr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] cur_ds_x,
  input  logic [31:0] cur_ds_y,
  input  logic [31:0] cur_ds_z,
  input  logic [31:0] cur_dt_x,
  input  logic [31:0] cur_dt_y,
  input  logic [31:0] cur_dt_z,
  input  logic [31:0] ref_ds_x,
  input  logic [31:0] ref_ds_y,
  input  logic [31:0] ref_ds_z,
  input  logic [31:0] ref_dt_x,
  input  logic [31:0] ref_dt_y,
  input  logic [31:0] ref_dt_z,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] red,
  output logic [31:0] green,
  output logic [31:0] blue,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef struct packed {
    flags_t      flags;
    logic [31:0] ld_c;
    logic [31:0] ld_r;
    logic [63:0] lc_c;
    logic [63:0] lc_r;
  } mid_t;

  logic        adv;
  mode_t       output_mode;
  logic        use_warning;
  logic [31:0] warn_red, warn_green, warn_blue;
  logic [31:0] fatal_red, fatal_green, fatal_blue;

  vec_t         ds [2];
  vec_t         dt [2];
  logic         fr_valid;
  logic [127:0] lc_rad [2];
  logic [63:0]  ld_rad [2];
  flags_t       fr_flags;

  logic         sq_valid;
  logic [63:0]  lc_c, lc_r;
  logic [31:0]  ld_c_raw, ld_r_raw, ld_c, ld_r;
  flags_t       sq_flags;

  logic         p_valid;
  logic [63:0]  p_c, p_r;
  mid_t         mid_in, mid;

  logic         t_valid;
  logic [31:0]  s_q, t_q, avg_q;
  flags_t       fin_flags;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = result_valid && result_stall;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= MODE_RGB;
      use_warning <= 1'b0;
      warn_red    <= 32'd0;
      warn_green  <= 32'd0;
      warn_blue   <= 32'd0;
      fatal_red   <= 32'h0001_0000;
      fatal_green <= 32'd0;
      fatal_blue  <= 32'h0001_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OUTPUT_MODE: output_mode <= mode_t'(cfg_data[1:0]);
        REG_USE_WARNING: use_warning <= cfg_data[0];
        REG_WARN_RED:    warn_red    <= cfg_data;
        REG_WARN_GREEN:  warn_green  <= cfg_data;
        REG_WARN_BLUE:   warn_blue   <= cfg_data;
        REG_FATAL_RED:   fatal_red   <= cfg_data;
        REG_FATAL_GREEN: fatal_green <= cfg_data;
        REG_FATAL_BLUE:  fatal_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ds[0] = '{x: cur_ds_x, y: cur_ds_y, z: cur_ds_z};
  assign dt[0] = '{x: cur_dt_x, y: cur_dt_y, z: cur_dt_z};
  assign ds[1] = '{x: ref_ds_x, y: ref_ds_y, z: ref_ds_z};
  assign dt[1] = '{x: ref_dt_x, y: ref_dt_y, z: ref_dt_z};

  ssr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (item_valid),
    .ds        (ds),
    .dt        (dt),
    .out_valid (fr_valid),
    .lc_rad    (lc_rad),
    .ld_rad    (ld_rad),
    .flags     (fr_flags)
  );

  ssr_sqrt #(.RW(64), .SW($bits(flags_t))) u_sqrt_lc_c (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (fr_valid), .rad (lc_rad[0]), .side_in (fr_flags),
    .out_valid (sq_valid), .root (lc_c), .side_out (sq_flags)
  );

  ssr_sqrt #(.RW(64), .SW(1)) u_sqrt_lc_r (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (fr_valid), .rad (lc_rad[1]), .side_in (1'b0),
    .out_valid (), .root (lc_r), .side_out ()
  );

  ssr_sqrt #(.RW(32), .SW(1)) u_sqrt_ld_c (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (fr_valid), .rad (ld_rad[0]), .side_in (1'b0),
    .out_valid (), .root (ld_c_raw), .side_out ()
  );

  ssr_sqrt #(.RW(32), .SW(1)) u_sqrt_ld_r (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (fr_valid), .rad (ld_rad[1]), .side_in (1'b0),
    .out_valid (), .root (ld_r_raw), .side_out ()
  );

  ssr_delay #(.W(32), .N(32)) u_dly_ld_c (
    .clk (clk), .adv (adv), .din (ld_c_raw), .dout (ld_c)
  );

  ssr_delay #(.W(32), .N(32)) u_dly_ld_r (
    .clk (clk), .adv (adv), .din (ld_r_raw), .dout (ld_r)
  );

  assign mid_in = '{flags: sq_flags, ld_c: ld_c, ld_r: ld_r, lc_c: lc_c, lc_r: lc_r};

  // perpendicular dt length: Lc * 2^32 / Ld
  ssr_div #(.DW(32), .QW(64), .SW($bits(mid_t))) u_div_p_c (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (sq_valid), .hi (lc_c[63:32]), .lo ({lc_c[31:0], 32'd0}), .den (ld_c),
    .side_in (mid_in), .out_valid (p_valid), .quot (p_c), .side_out (mid)
  );

  ssr_div #(.DW(32), .QW(64), .SW(1)) u_div_p_r (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (sq_valid), .hi (lc_r[63:32]), .lo ({lc_r[31:0], 32'd0}), .den (ld_r),
    .side_in (1'b0), .out_valid (), .quot (p_r), .side_out ()
  );

  ssr_div #(.DW(32), .QW(32), .SW(1)) u_div_s (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (p_valid), .hi ({16'd0, mid.ld_c[31:16]}), .lo ({mid.ld_c[15:0], 16'd0}),
    .den (mid.ld_r), .side_in (1'b0), .out_valid (), .quot (s_q), .side_out ()
  );

  ssr_div #(.DW(64), .QW(32), .SW(1)) u_div_avg (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (p_valid), .hi ({16'd0, mid.lc_c[63:16]}), .lo ({mid.lc_c[15:0], 16'd0}),
    .den (mid.lc_r), .side_in (1'b0), .out_valid (), .quot (avg_q), .side_out ()
  );

  ssr_div #(.DW(64), .QW(32), .SW($bits(flags_t))) u_div_t (
    .clk (clk), .rst (rst), .adv (adv),
    .in_valid (p_valid), .hi ({16'd0, p_c[63:16]}), .lo ({p_c[15:0], 16'd0}),
    .den (p_r), .side_in (mid.flags), .out_valid (t_valid), .quot (t_q),
    .side_out (fin_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin_flags.cur_zero || fin_flags.ref_zero) begin
        red    <= use_warning ? warn_red   : fatal_red;
        green  <= use_warning ? warn_green : fatal_green;
        blue   <= use_warning ? warn_blue  : fatal_blue;
        status <= fin_flags.cur_zero ? STATUS_CUR : STATUS_REF;
      end else begin
        status <= STATUS_OK;
        case (output_mode)
          MODE_RGB: begin
            red <= s_q;   green <= t_q;   blue <= avg_q;
          end
          MODE_S: begin
            red <= s_q;   green <= s_q;   blue <= s_q;
          end
          MODE_T: begin
            red <= t_q;   green <= t_q;   blue <= t_q;
          end
          default: begin
            red <= avg_q; green <= avg_q; blue <= avg_q;
          end
        endcase
      end
    end
  end

endmodule

[sim/tb_surface_stretch_ratio_top.sv]
`timescale 1ns / 1ps

module tb_surface_stretch_ratio_top;
  import ssr_pkg::*;

  typedef logic [11:0][31:0] frame_pair_t;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] g;
    logic [31:0] b;
    logic [1:0]  st;
  } pixel_t;

  localparam int          LATENCY   = 168;
  localparam int          MAX_CYC   = 600000;
  localparam logic [63:0] SAT_Q16   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] SAT_WIDE  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [31:0] cur_ds_x, cur_ds_y, cur_ds_z, cur_dt_x, cur_dt_y, cur_dt_z;
  logic [31:0] ref_ds_x, ref_ds_y, ref_ds_z, ref_dt_x, ref_dt_y, ref_dt_z;
  logic        result_valid;
  logic        result_stall;
  logic [31:0] red, green, blue;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;

  surface_stretch_ratio_top u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .cur_ds_x(cur_ds_x), .cur_ds_y(cur_ds_y), .cur_ds_z(cur_ds_z),
    .cur_dt_x(cur_dt_x), .cur_dt_y(cur_dt_y), .cur_dt_z(cur_dt_z),
    .ref_ds_x(ref_ds_x), .ref_ds_y(ref_ds_y), .ref_ds_z(ref_ds_z),
    .ref_dt_x(ref_dt_x), .ref_dt_y(ref_dt_y), .ref_dt_z(ref_dt_z),
    .result_valid(result_valid), .result_stall(result_stall),
    .red(red), .green(green), .blue(blue), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow registers
  mode_t       sh_mode;
  logic        sh_use_warn;
  logic [31:0] sh_warn_r, sh_warn_g, sh_warn_b;
  logic [31:0] sh_fatal_r, sh_fatal_g, sh_fatal_b;

  frame_pair_t pending_frames[$];
  pixel_t      expected_pixels[$];
  frame_pair_t cur_frames;
  int          frames_queued;
  int          frames_sent;
  int          errors;
  int          cycles;
  logic        calm;
  logic        hold_frames;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] isqrt128(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] scaled_quot(logic [63:0] num, logic [63:0] den,
                                              int shift, logic [63:0] limit);
    logic [127:0] q;
    if (den == 0) return limit;
    q = ({64'd0, num} << shift) / {64'd0, den};
    return (q > {64'd0, limit}) ? limit : q[63:0];
  endfunction

  function automatic void frame_lengths(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                        logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                        output logic [63:0] len_ds,
                                        output logic [63:0] len_cross);
    logic signed [65:0] ax, ay, az, bx, by, bz, dx, dy, dz;
    logic [63:0] cx, cy, cz, mx, my, mz;
    ax = {{34{sx[31]}}, sx};
    ay = {{34{sy[31]}}, sy};
    az = {{34{sz[31]}}, sz};
    bx = {{34{tx[31]}}, tx};
    by = {{34{ty[31]}}, ty};
    bz = {{34{tz[31]}}, tz};
    dx = ay * bz - az * by;
    dy = az * bx - ax * bz;
    dz = ax * by - ay * bx;
    cx = dx[65] ? 64'(-dx) : dx[63:0];
    cy = dy[65] ? 64'(-dy) : dy[63:0];
    cz = dz[65] ? 64'(-dz) : dz[63:0];
    mx = ax[65] ? 64'(-ax) : ax[63:0];
    my = ay[65] ? 64'(-ay) : ay[63:0];
    mz = az[65] ? 64'(-az) : az[63:0];
    len_ds = isqrt128({64'd0, mx} * {64'd0, mx} + {64'd0, my} * {64'd0, my}
                      + {64'd0, mz} * {64'd0, mz});
    len_cross = isqrt128({64'd0, cx} * {64'd0, cx} + {64'd0, cy} * {64'd0, cy}
                         + {64'd0, cz} * {64'd0, cz});
  endfunction

  function automatic pixel_t predict_stretch(frame_pair_t f);
    logic [63:0] ldc, lcc, ldr, lcr, s, t, a, pc, pr;
    pixel_t      o;
    o.st = STATUS_OK;
    ldr = '0;
    lcr = '0;
    frame_lengths(f[0], f[1], f[2], f[3], f[4], f[5], ldc, lcc);
    if (lcc == 0) begin
      o.st = STATUS_CUR;
    end else begin
      frame_lengths(f[6], f[7], f[8], f[9], f[10], f[11], ldr, lcr);
      if (lcr == 0) o.st = STATUS_REF;
    end
    if (o.st != STATUS_OK) begin
      o.r = sh_use_warn ? sh_warn_r : sh_fatal_r;
      o.g = sh_use_warn ? sh_warn_g : sh_fatal_g;
      o.b = sh_use_warn ? sh_warn_b : sh_fatal_b;
      return o;
    end
    s  = scaled_quot(ldc, ldr, 16, SAT_Q16);
    a  = scaled_quot(lcc, lcr, 16, SAT_Q16);
    pc = scaled_quot(lcc, ldc, 32, SAT_WIDE);
    pr = scaled_quot(lcr, ldr, 32, SAT_WIDE);
    t  = scaled_quot(pc, pr, 16, SAT_Q16);
    case (sh_mode)
      MODE_RGB: begin o.r = s[31:0]; o.g = t[31:0]; o.b = a[31:0]; end
      MODE_S:   begin o.r = s[31:0]; o.g = s[31:0]; o.b = s[31:0]; end
      MODE_T:   begin o.r = t[31:0]; o.g = t[31:0]; o.b = t[31:0]; end
      default:  begin o.r = a[31:0]; o.g = a[31:0]; o.b = a[31:0]; end
    endcase
    return o;
  endfunction

  function automatic void add_expected(pixel_t p);
    expected_pixels = {expected_pixels, p};
  endfunction

  // request driver
  always @(posedge clk) begin
    frame_pair_t nxt;
    logic        present;
    cycles <= cycles + 1;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        add_expected(predict_stretch(cur_frames));
        frames_sent <= frames_sent + 1;
      end
      if (!(item_valid && item_stall)) begin
        present = pending_frames.size() > 0 && !hold_frames &&
                  (calm || $urandom_range(0, 99) >= 29);
        if (present) begin
          nxt = pending_frames.pop_front();
          cur_frames <= nxt;
          {ref_dt_z, ref_dt_y, ref_dt_x, ref_ds_z, ref_ds_y, ref_ds_x,
           cur_dt_z, cur_dt_y, cur_dt_x, cur_ds_z, cur_ds_y, cur_ds_x} <= nxt;
        end
        item_valid <= present;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result red=%h green=%h blue=%h status=%0d",
                   $time, red, green, blue, status);
          errors++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (red !== exp_px.r) begin
            $display("%0t: red expected %h actual %h", $time, exp_px.r, red);
            errors++;
          end
          if (green !== exp_px.g) begin
            $display("%0t: green expected %h actual %h", $time, exp_px.g, green);
            errors++;
          end
          if (blue !== exp_px.b) begin
            $display("%0t: blue expected %h actual %h", $time, exp_px.b, blue);
            errors++;
          end
          if (status !== exp_px.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_px.st, status);
            errors++;
          end
        end
      end
      result_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 29);
    end
  end

  always @(posedge clk) begin
    if (cycles > MAX_CYC) begin
      $display("FAIL surface_stretch_ratio_top");
      $finish;
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_OUTPUT_MODE: sh_mode     = mode_t'(d[1:0]);
      REG_USE_WARNING: sh_use_warn = d[0];
      REG_WARN_RED:    sh_warn_r   = d;
      REG_WARN_GREEN:  sh_warn_g   = d;
      REG_WARN_BLUE:   sh_warn_b   = d;
      REG_FATAL_RED:   sh_fatal_r  = d;
      REG_FATAL_GREEN: sh_fatal_g  = d;
      REG_FATAL_BLUE:  sh_fatal_b  = d;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (frames_sent != frames_queued || expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2:       return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return {16'($signed($urandom_range(0, 4)) - 16'sd2), 16'($urandom())};
      6:       return 32'($urandom_range(0, 3));
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic queue_frame(frame_pair_t f);
    pending_frames = {pending_frames, f};
    frames_queued++;
  endtask

  task automatic queue_random(int n);
    frame_pair_t f;
    int          k;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 12; j++) f[j] = rand_comp();
      k = $urandom_range(0, 99);
      // degenerate frames: dt parallel to ds, or a zero vector
      if (k < 8) begin
        if (k < 4) f[5:3] = f[2:0];
        else if (k < 6) f[5:3] = '0;
        else f[2:0] = '0;
      end else if (k < 16) begin
        if (k < 12) f[11:9] = f[8:6];
        else f[8:6] = '0;
      end
      queue_frame(f);
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    result_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {ref_dt_z, ref_dt_y, ref_dt_x, ref_ds_z, ref_ds_y, ref_ds_x,
     cur_dt_z, cur_dt_y, cur_dt_x, cur_ds_z, cur_ds_y, cur_ds_x} = '0;
    cur_frames = '0;
    frames_queued = 0;
    frames_sent = 0;
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    hold_frames = 1'b0;
    sh_mode = MODE_RGB;
    sh_use_warn = 1'b0;
    sh_warn_r = '0;
    sh_warn_g = '0;
    sh_warn_b = '0;
    sh_fatal_r = 32'h0001_0000;
    sh_fatal_g = '0;
    sh_fatal_b = 32'h0001_0000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: unit frames, extremes, degenerate and saturating cases
    queue_frame({32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000,
                 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000});
    queue_frame({12{32'h8000_0000}});
    queue_frame({12{32'h7FFF_FFFF}});
    queue_frame({32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h8000_0000,
                 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
    queue_frame({32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1,
                 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF});
    queue_frame({32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000,
                 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    queue_frame({32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000,
                 32'h3, 32'h2, 32'h1, 32'h3, 32'h2, 32'h1});
    queue_frame({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000});
    queue_frame({32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF});
    queue_frame({32'h0, 32'h20000, 32'h30000, 32'h0, 32'h0, 32'h10000,
                 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h10000});
    queue_frame({32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF,
                 32'h0, 32'h0, 32'h1, 32'h1, 32'h0, 32'h0});
    drain();

    write_reg(REG_OUTPUT_MODE, 32'(MODE_S));
    write_reg(REG_USE_WARNING, 32'h1);
    write_reg(REG_WARN_RED, 32'hFFFF_FFFF);
    write_reg(REG_WARN_GREEN, 32'h0);
    write_reg(REG_WARN_BLUE, 32'hA5A5_5A5A);
    queue_frame({32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000,
                 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    queue_frame({32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000,
                 32'h0, 32'h20000, 32'h0, 32'h0, 32'h0, 32'h30000});
    queue_random(200);
    drain();

    write_reg(REG_OUTPUT_MODE, 32'(MODE_T));
    write_reg(REG_USE_WARNING, 32'h0);
    write_reg(REG_FATAL_RED, 32'h0);
    write_reg(REG_FATAL_GREEN, 32'hFFFF_FFFF);
    write_reg(REG_FATAL_BLUE, 32'h5A5A_A5A5);
    calm = 1'b1;
    queue_random(200);
    drain();
    calm = 1'b0;

    write_reg(REG_OUTPUT_MODE, 32'(MODE_AVG));
    write_reg(REG_USE_WARNING, 32'h1);
    write_reg(REG_WARN_RED, $urandom());
    write_reg(REG_WARN_GREEN, $urandom());
    write_reg(REG_WARN_BLUE, $urandom());
    queue_random(100);
    while (frames_sent < frames_queued - 50) @(posedge clk);
    hold_frames = 1'b1;
    while (expected_pixels.size() != 0 || item_valid) @(posedge clk);
    hold_frames = 1'b0;
    queue_random(100);
    drain();

    write_reg(4'd9, 32'hFFFF_FFFF);
    write_reg(REG_OUTPUT_MODE, 32'(MODE_RGB));
    write_reg(REG_USE_WARNING, 32'h0);
    write_reg(REG_FATAL_RED, $urandom());
    write_reg(REG_FATAL_GREEN, $urandom());
    write_reg(REG_FATAL_BLUE, 32'hFFFF_FFFF);
    queue_random(350);
    drain();

    write_reg(REG_OUTPUT_MODE, 32'(MODE_S));
    write_reg(REG_USE_WARNING, 32'h1);
    queue_random(200);
    drain();

    if (expected_pixels.size() != 0) errors++;
    if (errors == 0) begin
      $display("PASS surface_stretch_ratio_top");
    end else begin
      $display("FAIL surface_stretch_ratio_top");
    end
    $finish;
  end

endmodule
